### rtl/le_pkg.sv
// ----------------------------------------------------------------------------
// le_pkg
// Shared types and constants for the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package le_pkg;

  // line store geometry
  localparam int LINE_MAX = 32;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);

  // character codes
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_DELETE    = 8'h7F;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DASH      = 8'h2D;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // command classes passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_KEEP,
    CMD_ERASE,
    CMD_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [6:0] ch;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_ERASE,
    ST_LINE
  } back_state_t;

  // back end status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             in_line;
  } back_status_t;

endpackage

`default_nettype wire

### rtl/le_front.sv
// ----------------------------------------------------------------------------
// le_front
// Accepts received bytes and classifies them into editor commands.
// ----------------------------------------------------------------------------
`default_nettype none

module le_front
  import le_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_wdata
);

  logic kept;

  // letters, digits, space and dash are stored
  always_comb begin
    kept = ((rx_byte >= 8'h30) && (rx_byte <= 8'h39)) ||
           ((rx_byte >= 8'h41) && (rx_byte <= 8'h5A)) ||
           ((rx_byte >= 8'h61) && (rx_byte <= 8'h7A)) ||
           (rx_byte == CH_SPACE) || (rx_byte == CH_DASH);
  end

  // classify the byte
  always_comb begin
    q_wdata.ch = rx_byte[6:0];
    priority if ((rx_byte == CH_CR) || (rx_byte == CH_LF)) begin
      q_wdata.op = CMD_END;
    end else if ((rx_byte == CH_BACKSPACE) || (rx_byte == CH_DELETE)) begin
      q_wdata.op = CMD_ERASE;
    end else if (kept) begin
      q_wdata.op = CMD_KEEP;
    end else begin
      q_wdata.op = CMD_NONE;
    end
  end

  // ignored bytes are consumed here and never reach the queue
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && (q_wdata.op != CMD_NONE);

endmodule

`default_nettype wire

### rtl/le_cmd_queue.sv
// ----------------------------------------------------------------------------
// le_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module le_cmd_queue
  import le_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      rvalid,
  output cmd_t      rdata
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full   = (fill == 2'd2);
  assign rvalid = (fill != 2'd0);
  assign rdata  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/le_back.sv
// ----------------------------------------------------------------------------
// le_back
// Executes editor commands: keeps the line store and drives the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module le_back
  import le_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire cmd_t  q_rdata,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_kind,
  output logic [6:0] out_byte,
  output logic       run_last,
  output back_status_t status
);

  back_state_t      state, state_next;
  logic [CNT_W-1:0] line_count, line_count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [1:0]       step, step_next;
  logic [6:0]       cur_ch, cur_ch_next;

  logic             out_free;
  logic             out_load;
  logic             load_kind;
  logic [6:0]       load_byte;
  logic             load_last;
  logic             store_we;

  logic [6:0]       line_store [LINE_MAX];
  logic [6:0]       store_q;

  assign out_free       = !out_valid || out_ready;
  assign status.count   = line_count;
  assign status.in_line = (state == ST_LINE);

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_count <= '0;
      idx        <= '0;
      step       <= 2'd0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      idx        <= idx_next;
      step       <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_ch <= cur_ch_next;
  end

  // next state and result selection
  always_comb begin
    state_next      = state;
    line_count_next = line_count;
    idx_next        = idx;
    step_next       = step;
    cur_ch_next     = cur_ch;
    q_pop           = 1'b0;
    out_load        = 1'b0;
    load_kind       = KIND_ECHO;
    load_byte       = cur_ch;
    load_last       = 1'b0;
    store_we        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_rdata.op)
            CMD_KEEP: begin
              cur_ch_next = q_rdata.ch;
              state_next  = ST_ECHO;
            end
            CMD_ERASE: begin
              if (line_count != '0) begin
                line_count_next = line_count - CNT_W'(1);
                step_next       = 2'd0;
                state_next      = ST_ERASE;
              end
            end
            CMD_END: begin
              if (line_count != '0) begin
                idx_next   = '0;
                state_next = ST_LINE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          out_load        = 1'b1;
          load_kind       = KIND_ECHO;
          load_byte       = cur_ch;
          load_last       = (line_count != CNT_W'(LINE_MAX - 1));
          store_we        = 1'b1;
          line_count_next = line_count + CNT_W'(1);
          if (line_count == CNT_W'(LINE_MAX - 1)) begin
            idx_next   = '0;
            state_next = ST_LINE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERASE: begin
        // backspace, space, backspace
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = KIND_ECHO;
          load_byte = (step == 2'd1) ? CH_SPACE[6:0] : CH_BACKSPACE[6:0];
          load_last = (step == 2'd2);
          step_next = step + 2'd1;
          if (step == 2'd2) begin
            step_next  = 2'd0;
            state_next = ST_IDLE;
          end
        end
      end
      ST_LINE: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = KIND_LINE;
          load_byte = store_q;
          load_last = (CNT_W'(idx) == (line_count - CNT_W'(1)));
          if (load_last) begin
            line_count_next = '0;
            idx_next        = '0;
            state_next      = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // line store: one write port, registered read that tracks the next index
  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[line_count[IDX_W-1:0]] <= cur_ch;
    end
    store_q <= line_store[idx_next];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= load_kind;
      out_byte <= load_byte;
      run_last <= load_last;
    end
  end

endmodule

`default_nettype wire

### rtl/line_editor_with_echo.sv
// ----------------------------------------------------------------------------
// line_editor_with_echo
// Console line editor: echoes typed characters and emits completed lines.
// ----------------------------------------------------------------------------
// One received byte per input transaction. Letters, digits, space and dash
// are echoed and stored; backspace or delete on a non-empty line echoes
// backspace, space, backspace; carriage return or newline on a non-empty line
// sends the stored line; a character that fills the 32-byte store is echoed
// and then the whole line follows. Every other byte gives no result. Each
// result carries out_kind (0 echo, 1 line byte) and run_last marks the final
// result of an input byte. Bytes that give no result are taken at one per
// cycle while the command queue is not full. A line is sent at one byte per
// cycle from the store's registered read port while the receiver is ready.
// A two-entry command queue lets input be taken while results are still
// draining.
// ----------------------------------------------------------------------------
`default_nettype none

module line_editor_with_echo
  import le_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic [6:0]      out_byte,
  output logic            run_last
);

  logic         q_full;
  logic         q_push;
  cmd_t         q_wdata;
  logic         q_pop;
  logic         q_valid;
  cmd_t         q_rdata;
  back_status_t status;

  // front end: accept and classify
  le_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // command queue
  le_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // back end: line store and results
  le_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .status    (status)
  );

  // the store count never exceeds its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(LINE_MAX))
    else $error("line count above store depth");

  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command queue overflow");

  // line emission only runs on a non-empty line
  a_line_nonempty: assert property (@(posedge clk) disable iff (rst)
    status.in_line |-> (status.count != '0))
    else $error("line emission with empty store");

  // a line byte result only comes from line emission
  a_line_kind: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && (out_kind == KIND_LINE) |-> $past(status.in_line))
    else $error("line byte outside line emission");

endmodule

`default_nettype wire

### tb/sv/line_editor_with_echo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_with_echo_tb
// Self-checking bench for the console line editor with echo.
// ----------------------------------------------------------------------------
// A queue of received bytes is built up front: a short directed list (empty
// line ends and erases, ignored bytes, every character class, erase, line
// end), then random typed lines, some long enough to fill the store, with
// erases, stray bytes and noise bursts mixed in. A clocked driver offers the
// bytes, and a clocked monitor keeps a shadow copy of the line, predicts the
// echo and line bytes of each accepted byte, and checks every output
// transaction against them in order. Both sides idle at random. The receiver
// holds off once for a long stretch, and the sender waits for the results to
// drain before some bytes.
// ----------------------------------------------------------------------------

module line_editor_with_echo_tb;
  import le_pkg::*;

  localparam int RAND_ITEMS   = 320;
  localparam int RECV_HOLD    = 200;
  localparam int TAIL_CYCLES  = 50;

  typedef struct packed {
    logic       kind;
    logic [6:0] ch;
    logic       last;
  } term_char_t;

  typedef struct packed {
    logic [7:0] data;
    logic       drain;
  } rx_item_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_kind;
  logic [6:0] out_byte;
  logic       run_last;

  rx_item_t   rx_pending_q[$];
  term_char_t expected_chars_q[$];
  term_char_t step_chars_q[$];

  // shadow of the line store
  logic [6:0] shadow_line [LINE_MAX];
  int         shadow_len;

  logic       in_fire;
  int         accepted_cnt;
  int         err_cnt;
  int         hold_left;
  bit         hold_done;
  bit         drain_next;

  line_editor_with_echo i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // character classes that get stored: digits, letters, space, dash
  function automatic bit is_line_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_SPACE || b == CH_DASH;
  endfunction

  function automatic logic [7:0] rand_line_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'h41 + 8'($urandom_range(0, 25));
      3, 4, 5: c = 8'h61 + 8'($urandom_range(0, 25));
      6, 7:    c = 8'h30 + 8'($urandom_range(0, 9));
      8:       c = CH_SPACE;
      default: c = CH_DASH;
    endcase
    return c;
  endfunction

  // a byte the editor drops: punctuation below the dash or high bytes
  function automatic logic [7:0] rand_stray_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) c = 8'h80 + 8'($urandom_range(0, 127));
    else c = 8'h21 + 8'($urandom_range(0, 11));
    return c;
  endfunction

  task automatic queue_rx(input logic [7:0] b);
    rx_item_t it;
    it.data = b;
    it.drain = drain_next;
    drain_next = 1'b0;
    rx_pending_q.push_back(it);
  endtask

  task automatic push_step_char(input logic kind, input logic [6:0] ch);
    term_char_t r;
    r.kind = kind;
    r.ch = ch;
    r.last = 1'b0;
    step_chars_q.push_back(r);
  endtask

  task automatic flush_shadow_line();
    for (int k = 0; k < shadow_len; k++) push_step_char(KIND_LINE, shadow_line[k]);
    shadow_len = 0;
  endtask

  // predict the results of one accepted byte and queue them
  task automatic edit_line_predict(input logic [7:0] b);
    step_chars_q.delete();
    if (b == CH_CR || b == CH_LF) begin
      if (shadow_len > 0) flush_shadow_line();
    end else if (b == CH_BACKSPACE || b == CH_DELETE) begin
      if (shadow_len > 0) begin
        shadow_len--;
        push_step_char(KIND_ECHO, CH_BACKSPACE[6:0]);
        push_step_char(KIND_ECHO, CH_SPACE[6:0]);
        push_step_char(KIND_ECHO, CH_BACKSPACE[6:0]);
      end
    end else if (is_line_char(b)) begin
      push_step_char(KIND_ECHO, b[6:0]);
      if (shadow_len < LINE_MAX) begin
        shadow_line[shadow_len] = b[6:0];
        shadow_len++;
      end
      if (shadow_len >= LINE_MAX) flush_shadow_line();
    end
    if (step_chars_q.size() > 0) step_chars_q[step_chars_q.size()-1].last = 1'b1;
    for (int k = 0; k < step_chars_q.size(); k++) expected_chars_q.push_back(step_chars_q[k]);
  endtask

  // driver: offers the next byte, idling at random outside a quiet stretch
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (rx_pending_q.size() != 0 &&
          !(rx_pending_q[0].drain && expected_chars_q.size() != 0) &&
          $urandom_range(0, 99) >= ((accepted_cnt >= 120 && accepted_cnt < 200) ? 0 : 10)) begin
        rx_byte  <= rx_pending_q[0].data;
        in_valid <= 1'b1;
        rx_pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 60) begin
      hold_done <= 1'b1;
      hold_left <= RECV_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= ((accepted_cnt >= 120 && accepted_cnt < 200) ? 0 : 10);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    term_char_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        edit_line_predict(rx_byte);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected output transaction: kind %0d byte 0x%02h last %0d",
                 out_kind, out_byte, run_last);
          err_cnt++;
        end else begin
          want = expected_chars_q.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            err_cnt++;
          end
          if (out_byte !== want.ch) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.ch, out_byte);
            err_cnt++;
          end
          if (run_last !== want.last) begin
            $error("run_last mismatch: expected %0d, actual %0d", want.last, run_last);
            err_cnt++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int busy_items;
    int len;
    int pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    out_ready    = 1'b0;
    in_fire      = 1'b0;
    accepted_cnt = 0;
    err_cnt      = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    drain_next   = 1'b0;
    shadow_len   = 0;

    // directed: empty line end and erase, dropped bytes, each class, erase, end
    queue_rx(CH_CR);
    queue_rx(CH_LF);
    queue_rx(CH_BACKSPACE);
    queue_rx(CH_DELETE);
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_rx(8'h80);
    queue_rx(8'h2F);
    queue_rx(8'h3A);
    queue_rx(8'h40);
    queue_rx(8'h5B);
    queue_rx(8'h60);
    queue_rx(8'h7B);
    queue_rx(8'h41);
    queue_rx(8'h5A);
    queue_rx(8'h61);
    queue_rx(8'h7A);
    queue_rx(8'h30);
    queue_rx(8'h39);
    queue_rx(CH_SPACE);
    queue_rx(CH_DASH);
    queue_rx(CH_BACKSPACE);
    queue_rx(CH_DELETE);
    queue_rx(CH_CR);
    queue_rx(8'h78);
    queue_rx(CH_LF);

    // random: one line that overfills the store, then mostly typed lines
    drain_next = 1'b1;
    busy_items = 0;
    for (int k = 0; k < LINE_MAX + 5; k++) begin
      queue_rx(rand_line_char());
      busy_items++;
    end
    queue_rx(CH_CR);
    while (rx_pending_q.size() < RAND_ITEMS) begin
      if (busy_items >= 200 && busy_items < 210) drain_next = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            queue_rx(($urandom_range(0, 1) == 1) ? CH_BACKSPACE : CH_DELETE);
            busy_items++;
          end else if (pick < 14) begin
            queue_rx(rand_stray_byte());
          end else begin
            queue_rx(rand_line_char());
            busy_items++;
          end
        end
        queue_rx(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
        busy_items++;
      end else begin
        // noise burst of arbitrary bytes
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) queue_rx(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (rx_pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### line_editor_with_echo.f
rtl/le_pkg.sv
rtl/le_front.sv
rtl/le_cmd_queue.sv
rtl/le_back.sv
rtl/line_editor_with_echo.sv
tb/sv/line_editor_with_echo_tb.sv
